@@ rtl/core/tlvp_pkg.sv @@
// tlvp_pkg: shared types and constants of the type-length-value parameter parser
// no dependencies; used by the interfaces, tlvp_step and tlv_parameter_parser

package tlvp_pkg;

	// bytes of packet header that precede the data region
	localparam logic [7:0] HEADER_OVERHEAD = 8'd11;

	// largest fixed value size in bytes; a larger size code means custom size
	localparam logic [3:0] MAX_VALUE_BYTES = 4'd4;

	// parser phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_VALUE = 2'd1,
		PH_CLEN  = 2'd2,
		PH_SKIP  = 2'd3
	} phase_t;

	// one input beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic [7:0] packet_length;
	} byte_beat_t;

	// one result beat
	typedef struct packed {
		logic [5:0]  param_type;
		logic [7:0]  param_size;
		logic [31:0] param_value;
		logic        custom_sized;
		logic        truncated;
	} param_beat_t;

endpackage

@@ rtl/core/tlvp_if.sv @@
// tlvp_if: valid/ready channels of the parser, one for bytes and one for results
// depends on tlvp_pkg for the payload types

interface tlvp_byte_if;
	logic                   valid;
	logic                   ready;
	tlvp_pkg::byte_beat_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface tlvp_param_if;
	logic                   valid;
	logic                   ready;
	tlvp_pkg::param_beat_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/tlvp_step.sv @@
// tlvp_step: parser state registers and the per-byte state update
// depends on tlvp_pkg; instantiated by tlv_parameter_parser

module tlvp_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  tlvp_pkg::byte_beat_t  item,
	output logic                  emit,
	output tlvp_pkg::param_beat_t result
);

	tlvp_pkg::phase_t phase_q, e_phase, n_phase;
	logic [7:0]  region_q, e_region, n_region;
	logic [7:0]  left_q, e_left, n_left;
	logic [5:0]  type_q, n_type;
	logic [7:0]  size_q, n_size;
	logic [31:0] acc_q, e_acc, n_acc;
	logic [1:0]  bpos_q, e_bpos, n_bpos;
	logic        custom_q, e_custom, n_custom;
	logic        last;
	logic        trunc;
	logic [3:0]  hdr_size;
	logic [4:0]  lane_lsb;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tlvp_pkg::PH_IDLE;
			region_q <= '0;
			left_q   <= '0;
			type_q   <= '0;
			size_q   <= '0;
			acc_q    <= '0;
			bpos_q   <= '0;
			custom_q <= 1'b0;
		end else if (en) begin
			phase_q  <= n_phase;
			region_q <= n_region;
			left_q   <= n_left;
			type_q   <= n_type;
			size_q   <= n_size;
			acc_q    <= n_acc;
			bpos_q   <= n_bpos;
			custom_q <= n_custom;
		end
	end

	// size from the header's top two bits: 1, 2, 4, or 8 for custom
	assign hdr_size = 4'd1 << item.data_byte[7:6];
	assign lane_lsb = {e_bpos, 3'b000};

	// restart on a first byte, then one step of the parser
	always_comb begin
		e_phase  = phase_q;
		e_region = region_q;
		e_left   = left_q;
		e_acc    = acc_q;
		e_bpos   = bpos_q;
		e_custom = custom_q;
		if (item.first_byte) begin
			e_phase  = tlvp_pkg::PH_IDLE;
			e_region = (item.packet_length > tlvp_pkg::HEADER_OVERHEAD) ?
				item.packet_length - tlvp_pkg::HEADER_OVERHEAD : 8'd0;
			e_left   = '0;
			e_acc    = '0;
			e_bpos   = '0;
			e_custom = 1'b0;
		end

		n_phase  = e_phase;
		n_region = e_region;
		n_left   = e_left;
		n_type   = type_q;
		n_size   = size_q;
		n_acc    = e_acc;
		n_bpos   = e_bpos;
		n_custom = e_custom;
		emit     = 1'b0;
		trunc    = 1'b0;
		last     = (e_region == 8'd1);

		if (e_region != 8'd0) begin
			n_region = e_region - 8'd1;
			unique case (e_phase)
				tlvp_pkg::PH_IDLE: begin
					n_type = item.data_byte[5:0];
					n_acc  = '0;
					n_bpos = '0;
					if (hdr_size > tlvp_pkg::MAX_VALUE_BYTES) begin
						n_custom = 1'b1;
						n_size   = '0;
						n_phase  = tlvp_pkg::PH_CLEN;
					end else begin
						n_custom = 1'b0;
						n_size   = {4'b0000, hdr_size};
						n_left   = {4'b0000, hdr_size};
						n_phase  = tlvp_pkg::PH_VALUE;
					end
					if (last) begin
						emit  = 1'b1;
						trunc = 1'b1;
					end
				end
				tlvp_pkg::PH_VALUE: begin
					n_acc[lane_lsb +: 8] = e_acc[lane_lsb +: 8] | item.data_byte;
					n_bpos = e_bpos + 2'd1;
					n_left = e_left - 8'd1;
					if (n_left == 8'd0) begin
						emit = 1'b1;
					end else if (last) begin
						emit  = 1'b1;
						trunc = 1'b1;
					end
				end
				tlvp_pkg::PH_CLEN: begin
					n_size = item.data_byte;
					n_left = item.data_byte;
					if (item.data_byte == 8'd0) begin
						emit = 1'b1;
					end else begin
						n_phase = tlvp_pkg::PH_SKIP;
						if (last) begin
							emit  = 1'b1;
							trunc = 1'b1;
						end
					end
				end
				tlvp_pkg::PH_SKIP: begin
					n_left = e_left - 8'd1;
					if (n_left == 8'd0) begin
						emit = 1'b1;
					end else if (last) begin
						emit  = 1'b1;
						trunc = 1'b1;
					end
				end
				default: begin
					n_phase = tlvp_pkg::PH_IDLE;
				end
			endcase
		end

		// a finished parameter returns to header search
		if (emit) begin
			n_phase = tlvp_pkg::PH_IDLE;
		end
	end

	// result fields from the updated state
	always_comb begin
		result.param_type   = n_type;
		result.param_size   = n_size;
		result.param_value  = n_acc;
		result.custom_sized = n_custom;
		result.truncated    = trunc;
	end

endmodule

@@ rtl/core/tlv_parameter_parser.sv @@
// tlv_parameter_parser: splits a sensor payload byte stream into type-length-value parameters
// depends on tlvp_pkg, tlvp_if (tlvp_byte_if, tlvp_param_if) and tlvp_step
//
//   channel     dir  beat          handshake
//   in_bytes    in   byte_beat_t   valid/ready
//   out_params  out  param_beat_t  valid/ready
//
// one byte per cycle sustained while out_params does not stall: a byte is registered in the
// input register, then parsed, and a finished parameter lands in the result register
// the parser state update is combinational and feeds back into the state registers
// reset clears the parser state; bytes before the first first_byte are ignored
// a stall on out_params holds the input register and the parser, and
// in_bytes.ready drops only while both registers are full

module tlv_parameter_parser (
	input  logic                clk,
	input  logic                arst_n,
	tlvp_byte_if.sink           in_bytes,
	tlvp_param_if.source        out_params
);

	logic                  valid_s1;
	tlvp_pkg::byte_beat_t  item_s1;
	logic                  valid_s2;
	tlvp_pkg::param_beat_t result_s2;
	logic                  advance;
	logic                  emit;
	tlvp_pkg::param_beat_t result;

	// the pipeline moves whenever the result register is free or being taken
	assign advance        = !valid_s2 || out_params.ready;
	assign in_bytes.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_bytes.ready) begin
			valid_s1 <= in_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_bytes.valid && in_bytes.ready) begin
			item_s1 <= in_bytes.payload;
		end
	end

	// parser state and step logic
	tlvp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.item   (item_s1),
		.emit   (emit),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			result_s2 <= result;
		end
	end

	assign out_params.valid   = valid_s2;
	assign out_params.payload = result_s2;

	// back pressure on the input only when both registers are full and stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_bytes.ready |-> (valid_s1 && valid_s2 && !out_params.ready))
		else $error("input stalled without a full, stalled pipeline");

	// custom parameters always report a zero value
	a_custom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_params.valid && out_params.payload.custom_sized)
			|-> (out_params.payload.param_value == 32'd0))
		else $error("custom-sized parameter with nonzero value");

	// fixed parameters carry a size of 1, 2 or 4
	a_fixed_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_params.valid && !out_params.payload.custom_sized)
			|-> (out_params.payload.param_size == 8'd1 ||
			     out_params.payload.param_size == 8'd2 ||
			     out_params.payload.param_size == 8'd4))
		else $error("fixed-size parameter with illegal size");

endmodule
